>>> rtl/ordered_record_list_defines.svh
// Assertion macros shared by the ordered record list RTL.
`ifndef ORDERED_RECORD_LIST_DEFINES_SVH
`define ORDERED_RECORD_LIST_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ORL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ORL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/orl_pkg.sv
// Package with the shared constants and types of the ordered record list.
`timescale 1ns / 1ps
package orl_pkg;

    localparam int DEPTH      = 16;
    localparam int NAME_BYTES = 8;

    localparam int NAME_W = 64;
    localparam int KEY_W  = 32;
    localparam int REC_W  = NAME_W + KEY_W;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;
    localparam int REQ_W  = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES);

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_FIND   = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_RANGE = 3'd1,
        STAT_TAKEN = 3'd2,
        STAT_FULL  = 3'd3,
        STAT_MISS  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_FETCH,
        ST_SHIFT_DN
    } state_t;

endpackage

>>> rtl/ordered_record_list.sv
// Ordered record list: positional insert, delete, read and find over a record RAM.
//
// One request is taken when start is high and busy is low; busy then stays high
// until the request is finished (a rejected position is answered without busy
// going high), and the result appears on the result ports with done high for
// exactly one cycle, in the cycle after the request finishes. The result cannot
// be held off, so it must be taken when done is high. All records sit in one RAM
// with one read and one write port, and every walk or shift moves one entry per
// cycle (n is the record count before the request, p the position): find walks
// all n records, delete moves the records above p down one place, and insert
// walks all n records to check the name and then moves the records from p up
// one place (it stops after the walk when the name is taken or the list is
// full). The first request may be given in the cycle after reset.
`timescale 1ns / 1ps
`include "ordered_record_list_defines.svh"
module ordered_record_list (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [orl_pkg::REQ_W-1:0]  req_type,
    input  logic [orl_pkg::POS_W-1:0]  position,
    input  logic [orl_pkg::NAME_W-1:0] user_name,
    input  logic signed [orl_pkg::KEY_W-1:0] user_key,
    output logic                       done,
    output logic [orl_pkg::STAT_W-1:0] status,
    output logic [orl_pkg::POS_W-1:0]  found_position,
    output logic [orl_pkg::NAME_W-1:0] record_name,
    output logic signed [orl_pkg::KEY_W-1:0] record_key,
    output logic [orl_pkg::POS_W-1:0]  record_count
);
    import orl_pkg::*;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [NAME_W-1:0]   name_reg, name_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [CNT_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                hit_reg, hit_next;
    logic [CNT_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [NAME_W-1:0]   rec_name_reg, rec_name_next;
    logic [KEY_W-1:0]    rec_key_reg, rec_key_next;

    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [POS_W-1:0]    fpos_reg, fpos_next;
    logic [NAME_W-1:0]   oname_reg, oname_next;
    logic [KEY_W-1:0]    okey_reg, okey_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [REC_W-1:0]    ram_wr_data;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [REC_W-1:0]    ram_rd_data;
    logic [NAME_W-1:0]   rd_name;
    logic [KEY_W-1:0]    rd_key;
    logic                rd_match;
    logic [CMP_W-1:0]    pos_cmp, count_cmp, idx_cmp, pos_in_cmp;
    logic [CNT_W-1:0]    pos_cnt, pos_in_cnt;

    orl_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_name    = ram_rd_data[REC_W-1:KEY_W];
    assign rd_key     = ram_rd_data[KEY_W-1:0];
    assign pos_cmp    = CMP_W'(pos_reg);
    assign pos_in_cmp = CMP_W'(position);
    assign count_cmp  = CMP_W'(count_reg);
    assign idx_cmp    = CMP_W'(idx_reg);
    assign pos_cnt    = CNT_W'(pos_reg);
    assign pos_in_cnt = CNT_W'(position);

    // Find needs the key to match as well; the insert check looks at the name alone.
    assign rd_match = (rd_name == name_reg) && ((req_reg != REQ_FIND) || (rd_key == key_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pos_reg      <= pos_next;
        name_reg     <= name_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        rec_name_reg <= rec_name_next;
        rec_key_reg  <= rec_key_next;
        status_reg   <= status_next;
        fpos_reg     <= fpos_next;
        oname_reg    <= oname_next;
        okey_reg     <= okey_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        pos_next      = pos_reg;
        name_next     = name_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        rec_name_next = rec_name_reg;
        rec_key_next  = rec_key_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        fpos_next     = fpos_reg;
        oname_next    = oname_reg;
        okey_next     = okey_reg;
        ram_we        = 1'b0;
        ram_wr_addr   = '0;
        ram_wr_data   = '0;
        ram_rd_addr   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_t'(req_type);
                    pos_next   = position;
                    name_next  = user_name & NAME_MASK;
                    key_next   = user_key;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    oname_next = '0;
                    okey_next  = '0;
                    fpos_next  = '0;
                    unique case (req_t'(req_type))
                        REQ_INSERT:
                        begin
                            if ((position == '0) || (pos_in_cmp > count_cmp + CMP_W'(1)))
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_DELETE, REQ_READ:
                        begin
                            if ((position == '0) || (pos_in_cmp > count_cmp))
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                ram_rd_addr = ADDR_W'(pos_in_cnt - CNT_W'(1));
                                state_next  = ST_FETCH;
                            end
                        end
                        REQ_FIND:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (pend_reg && rd_match && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = pend_idx_reg;
                end
                if (idx_reg < count_reg)
                begin
                    ram_rd_addr   = idx_reg[ADDR_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (req_reg == REQ_FIND)
                        begin
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                            status_next = hit_reg ? STAT_OK : STAT_MISS;
                            fpos_next   = hit_reg ? POS_W'(hit_idx_reg + CNT_W'(1)) : '0;
                        end
                        else if (hit_reg)
                        begin
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                            status_next = STAT_TAKEN;
                        end
                        else if (count_cmp >= CMP_W'(DEPTH))
                        begin
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = ST_SHIFT_UP;
                        end
                    end
                end
            end

            // idx_reg is the next slot to fill; the record below it moves up one place.
            ST_SHIFT_UP:
            begin
                if (pend_reg)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = ADDR_W'(pend_idx_reg + CNT_W'(1));
                    ram_wr_data = ram_rd_data;
                end
                if (idx_cmp >= pos_cmp)
                begin
                    ram_rd_addr   = ADDR_W'(idx_reg - CNT_W'(1));
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg - CNT_W'(1);
                    idx_next      = idx_reg - CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ram_we      = 1'b1;
                        ram_wr_addr = ADDR_W'(pos_cnt - CNT_W'(1));
                        ram_wr_data = {name_reg, key_reg};
                        count_next  = count_reg + CNT_W'(1);
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                        status_next = STAT_OK;
                        fpos_next   = pos_reg;
                    end
                end
            end

            ST_FETCH:
            begin
                rec_name_next = rd_name;
                rec_key_next  = rd_key;
                if (req_reg == REQ_DELETE)
                begin
                    idx_next   = pos_cnt;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT_DN;
                end
                else
                begin
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                    status_next = STAT_OK;
                    fpos_next   = pos_reg;
                    oname_next  = rd_name;
                    okey_next   = rd_key;
                end
            end

            // idx_reg is the next record to move down one place over the removed one.
            ST_SHIFT_DN:
            begin
                if (pend_reg)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = ADDR_W'(pend_idx_reg - CNT_W'(1));
                    ram_wr_data = ram_rd_data;
                end
                if (idx_reg < count_reg)
                begin
                    ram_rd_addr   = idx_reg[ADDR_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                        status_next = STAT_OK;
                        fpos_next   = pos_reg;
                        oname_next  = rec_name_reg;
                        okey_next   = rec_key_reg;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found_position = fpos_reg;
    assign record_name    = oname_reg;
    assign record_key     = okey_reg;
    assign record_count   = POS_W'(count_reg);

    `ORL_ASSERT_NOW(a_count_bound, 1'b1, count_cmp <= CMP_W'(DEPTH), "record count above depth")
    `ORL_ASSERT_NOW(a_write_busy, ram_we, state_reg != ST_IDLE, "RAM written while idle")
    `ORL_ASSERT_NOW(a_pend_busy, pend_reg, state_reg != ST_IDLE, "read pending while idle")
    `ORL_ASSERT_NOW(a_err_pos, done_reg && (status_reg != STAT_OK), fpos_reg == '0, "position on error")
    `ORL_ASSERT_NEXT(a_accept_busy, start && !busy && (req_type == REQ_FIND), busy, "find not started")

endmodule

>>> rtl/orl_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module orl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> tb/ordered_record_list_checker.sv
// Checker for the ordered record list: predicts every request's result and compares it.
`timescale 1ns / 1ps
module ordered_record_list_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [orl_pkg::REQ_W-1:0]         req_type,
    input  logic [orl_pkg::POS_W-1:0]         position,
    input  logic [orl_pkg::NAME_W-1:0]        user_name,
    input  logic signed [orl_pkg::KEY_W-1:0]  user_key,
    input  logic                              done,
    input  logic [orl_pkg::STAT_W-1:0]        status,
    input  logic [orl_pkg::POS_W-1:0]         found_position,
    input  logic [orl_pkg::NAME_W-1:0]        record_name,
    input  logic signed [orl_pkg::KEY_W-1:0]  record_key,
    input  logic [orl_pkg::POS_W-1:0]         record_count,
    output int                                fail_count,
    output int                                awaited
);
    import orl_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]       st;
        logic [POS_W-1:0]        fpos;
        logic [NAME_W-1:0]       nm;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        cnt;
    } list_outcome_t;

    logic [NAME_W-1:0]       list_names [DEPTH];
    logic signed [KEY_W-1:0] list_keys  [DEPTH];
    int                      list_len = 0;
    list_outcome_t           pending_outcomes [$];

    initial
    begin
        fail_count = 0;
        awaited    = 0;
    end

    // Applies one request to the shadow list and returns the result it must give.
    function automatic list_outcome_t apply_request(
        input logic [REQ_W-1:0]      kind,
        input logic [POS_W-1:0]      pos,
        input logic [NAME_W-1:0]     name_in,
        input logic signed [KEY_W-1:0] key_in
    );
        list_outcome_t r;
        logic [NAME_W-1:0] nm;
        int p;
        int i;
        logic taken;
        r     = '0;
        r.st  = STAT_OK;
        p     = pos;
        nm    = name_in & NAME_MASK;
        taken = 1'b0;
        case (kind)
            REQ_INSERT:
            begin
                // The key takes no part in the duplicate-name test.
                for (i = 0; i < list_len; i++)
                    if (list_names[i] == nm)
                        taken = 1'b1;
                if (p < 1 || p > list_len + 1)
                    r.st = STAT_RANGE;
                else if (taken)
                    r.st = STAT_TAKEN;
                else if (list_len >= DEPTH)
                    r.st = STAT_FULL;
                else
                begin
                    for (i = list_len; i >= p; i--)
                    begin
                        list_names[i] = list_names[i-1];
                        list_keys[i]  = list_keys[i-1];
                    end
                    list_names[p-1] = nm;
                    list_keys[p-1]  = key_in;
                    list_len++;
                    r.fpos = POS_W'(p);
                end
            end
            REQ_DELETE, REQ_READ:
            begin
                if (p < 1 || p > list_len)
                    r.st = STAT_RANGE;
                else
                begin
                    r.nm   = list_names[p-1];
                    r.key  = list_keys[p-1];
                    r.fpos = POS_W'(p);
                    if (kind == REQ_DELETE)
                    begin
                        for (i = p - 1; i + 1 < list_len; i++)
                        begin
                            list_names[i] = list_names[i+1];
                            list_keys[i]  = list_keys[i+1];
                        end
                        list_len--;
                    end
                end
            end
            default:
            begin
                r.st = STAT_MISS;
                for (i = 0; i < list_len; i++)
                    if (r.st == STAT_MISS && list_names[i] == nm && list_keys[i] == key_in)
                    begin
                        r.st   = STAT_OK;
                        r.fpos = POS_W'(i + 1);
                    end
            end
        endcase
        r.cnt = POS_W'(list_len);
        return r;
    endfunction

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_outcome_t want;
        if (!rst_n)
        begin
            list_len = 0;
            pending_outcomes.delete();
        end
        else
        begin
            // A result leaving in this cycle belongs to an earlier request, so it is
            // matched before any request taken at the same edge is predicted.
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no request waiting, status %0h count %0h",
                             $time, status, record_count);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    check_field("status", 64'(want.st), 64'(status));
                    check_field("found_position", 64'(want.fpos), 64'(found_position));
                    check_field("record_name", want.nm, record_name);
                    check_field("record_key", 64'(unsigned'(want.key)),
                                64'(unsigned'(record_key)));
                    check_field("record_count", 64'(want.cnt), 64'(record_count));
                end
            end
            if (start && !busy)
                pending_outcomes.push_back(apply_request(req_type, position, user_name,
                                                         user_key));
        end
        awaited = pending_outcomes.size();
    end

endmodule

>>> tb/ordered_record_list_test.sv
// Top of the ordered record list testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module ordered_record_list_test;
    import orl_pkg::*;

    localparam logic [NAME_W-1:0] NAME_ALPHA = 64'h0000_0000_0041_4C46;
    localparam logic [NAME_W-1:0] NAME_ZERO  = 64'h0;
    localparam logic [NAME_W-1:0] NAME_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [NAME_W-1:0] NAME_SHORT = 64'h0000_0000_0000_4142;
    localparam logic [NAME_W-1:0] NAME_GAP   = 64'h0000_4300_0000_4142;
    localparam logic [NAME_W-1:0] NAME_TOP   = 64'h8000_0000_0000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam int POOL_SIZE   = 24;
    localparam int RANDOM_REQS = 1830;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [REQ_W-1:0]        req_type = '0;
    logic [POS_W-1:0]        position = '0;
    logic [NAME_W-1:0]       user_name = '0;
    logic signed [KEY_W-1:0] user_key = '0;
    logic                    busy;
    logic                    done;
    logic [STAT_W-1:0]       status;
    logic [POS_W-1:0]        found_position;
    logic [NAME_W-1:0]       record_name;
    logic signed [KEY_W-1:0] record_key;
    logic [POS_W-1:0]        record_count;
    int                      fail_count;
    int                      awaited;

    // Last list length reported by the block; only used to aim positions.
    int                      seen_len = 0;
    logic [NAME_W-1:0]       name_pool [POOL_SIZE];
    logic signed [KEY_W-1:0] key_pool  [POOL_SIZE];

    ordered_record_list u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .position       (position),
        .user_name      (user_name),
        .user_key       (user_key),
        .done           (done),
        .status         (status),
        .found_position (found_position),
        .record_name    (record_name),
        .record_key     (record_key),
        .record_count   (record_count)
    );

    ordered_record_list_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .position       (position),
        .user_name      (user_name),
        .user_key       (user_key),
        .done           (done),
        .status         (status),
        .found_position (found_position),
        .record_name    (record_name),
        .record_key     (record_key),
        .record_count   (record_count),
        .fail_count     (fail_count),
        .awaited        (awaited)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (done)
            seen_len <= record_count;
    end

    // Presents one request and returns at the edge where the block takes it.
    task automatic issue(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                         input logic [NAME_W-1:0] nm, input logic signed [KEY_W-1:0] key);
        req_type  <= kind;
        position  <= pos;
        user_name <= nm;
        user_key  <= key;
        start     <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Now and then drops start for a random gap, with junk on the request fields.
    task automatic maybe_idle();
        int gap;
        if ($urandom_range(0, 99) < 22)
        begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap)
            begin
                req_type  <= REQ_W'($urandom);
                position  <= POS_W'($urandom);
                user_name <= {$urandom, $urandom};
                user_key  <= $urandom;
                @(posedge clk);
            end
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int n;
        int roll;
        int slot;
        int top_pos;
        bit quiet;
        logic [REQ_W-1:0] kind;
        logic [POS_W-1:0] pos;
        logic [NAME_W-1:0] nm;
        logic signed [KEY_W-1:0] key;
        int waited;

        name_pool[0] = NAME_ALPHA;
        name_pool[1] = NAME_ZERO;
        name_pool[2] = NAME_ONES;
        name_pool[3] = NAME_SHORT;
        name_pool[4] = NAME_GAP;
        name_pool[5] = NAME_TOP;
        key_pool[0] = KEY_MAX;
        key_pool[1] = KEY_MIN;
        key_pool[2] = -32'sd1;
        key_pool[3] = 32'sd0;
        key_pool[4] = 32'sd5;
        key_pool[5] = 32'sd1;
        for (n = 6; n < POOL_SIZE; n++)
        begin
            name_pool[n] = {$urandom, $urandom};
            // Some names carry a zero byte with non-zero bytes after it.
            if (n % 3 == 0)
                name_pool[n][23:16] = 8'h00;
            key_pool[n] = $urandom;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        issue(REQ_READ,   5'd1,  NAME_ZERO,  32'sd0);
        issue(REQ_DELETE, 5'd0,  NAME_ZERO,  32'sd0);
        issue(REQ_FIND,   5'd0,  NAME_ALPHA, KEY_MAX);
        issue(REQ_INSERT, 5'd0,  NAME_ALPHA, KEY_MAX);
        issue(REQ_INSERT, 5'd2,  NAME_ALPHA, KEY_MAX);
        issue(REQ_INSERT, 5'd1,  NAME_ALPHA, KEY_MAX);
        issue(REQ_INSERT, 5'd1,  NAME_ZERO,  KEY_MIN);
        issue(REQ_INSERT, 5'd3,  NAME_ONES,  -32'sd1);
        issue(REQ_INSERT, 5'd2,  NAME_ALPHA, 32'sd0);
        issue(REQ_INSERT, 5'd5,  NAME_GAP,   32'sd5);
        issue(REQ_INSERT, 5'd4,  NAME_GAP,   32'sd5);
        issue(REQ_FIND,   5'd16, NAME_SHORT, 32'sd5);
        issue(REQ_INSERT, 5'd5,  NAME_SHORT, 32'sd5);
        issue(REQ_FIND,   5'd0,  NAME_ZERO,  KEY_MIN);
        issue(REQ_FIND,   5'd0,  NAME_ALPHA, 32'sd0);
        issue(REQ_FIND,   5'd31, NAME_ONES,  -32'sd1);
        issue(REQ_READ,   5'd0,  NAME_ZERO,  32'sd0);
        issue(REQ_READ,   5'd16, NAME_ZERO,  32'sd0);
        issue(REQ_READ,   5'd5,  NAME_ZERO,  32'sd0);
        issue(REQ_READ,   5'd1,  NAME_ONES,  -32'sd1);
        issue(REQ_DELETE, 5'd6,  NAME_ZERO,  32'sd0);
        issue(REQ_DELETE, 5'd1,  NAME_ZERO,  32'sd0);
        issue(REQ_DELETE, 5'd4,  NAME_ZERO,  32'sd0);
        issue(REQ_DELETE, 5'd2,  NAME_ZERO,  32'sd0);

        for (n = 0; n < RANDOM_REQS; n++)
        begin
            // Phases that fill the list, drain it and mix, so that it swings
            // between empty and full.
            roll = $urandom_range(0, 99);
            case ((n / 150) % 3)
                0:       kind = roll < 55 ? REQ_INSERT : roll < 65 ? REQ_DELETE :
                                roll < 80 ? REQ_READ : REQ_FIND;
                1:       kind = roll < 15 ? REQ_INSERT : roll < 60 ? REQ_DELETE :
                                roll < 80 ? REQ_READ : REQ_FIND;
                default: kind = roll < 35 ? REQ_INSERT : roll < 60 ? REQ_DELETE :
                                roll < 78 ? REQ_READ : REQ_FIND;
            endcase
            slot = $urandom_range(0, POOL_SIZE - 1);
            nm   = ($urandom_range(0, 99) < 88) ? name_pool[slot] : {$urandom, $urandom};
            roll = $urandom_range(0, 99);
            key  = roll < 75 ? key_pool[slot] : roll < 88 ? key_pool[slot] ^ 32'sd1 :
                   $signed($urandom);
            if ($urandom_range(0, 99) < 80)
            begin
                top_pos = (kind == REQ_INSERT) ? seen_len + 1 : seen_len;
                if (top_pos > DEPTH)
                    top_pos = DEPTH;
                if (top_pos < 1)
                    top_pos = 1;
                pos = POS_W'($urandom_range(1, top_pos));
            end
            else
                pos = POS_W'($urandom_range(0, DEPTH));
            quiet = (n >= 700 && n < 1000);
            if (!quiet)
                maybe_idle();
            issue(kind, pos, nm, key);
        end
        start <= 1'b0;

        waited = 0;
        while (awaited != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (fail_count == 0 && awaited == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
